@@ design/zap_pkg.sv @@
// types, codes and constants shared by the zoned alarm panel files
package zap_pkg;

    localparam int OUT_ZONES = 3;   // zones visible in masks and breach reports

    typedef logic [1:0]         t_op;
    typedef logic signed [2:0]  t_zone_code;
    typedef logic [1:0]         t_mode;
    typedef logic [1:0]         t_zstate;
    typedef logic [3:0]         t_event;
    typedef logic [1:0]         t_cred;
    typedef logic [15:0]        t_ticks;
    typedef logic [OUT_ZONES-1:0] t_mask;

    localparam t_op OP_TICK   = 2'd0;
    localparam t_op OP_CODE   = 2'd1;
    localparam t_op OP_TAG    = 2'd2;
    localparam t_op OP_BREACH = 2'd3;

    localparam t_mode MODE_DISARMED  = 2'd0;
    localparam t_mode MODE_ARMED     = 2'd1;
    localparam t_mode MODE_TRIGGERED = 2'd2;

    localparam t_zstate ZS_DISARMED  = 2'd0;
    localparam t_zstate ZS_ARMED     = 2'd1;
    localparam t_zstate ZS_TRIGGERED = 2'd2;

    localparam t_event EV_NONE        = 4'd0;
    localparam t_event EV_CODE_DENIED = 4'd1;
    localparam t_event EV_CODE_OK     = 4'd2;
    localparam t_event EV_TAG_REJECT  = 4'd3;
    localparam t_event EV_TIMEOUT     = 4'd4;
    localparam t_event EV_ARMED       = 4'd5;
    localparam t_event EV_ZONE_DISARM = 4'd6;
    localparam t_event EV_SYS_DISARM  = 4'd7;
    localparam t_event EV_BREACH      = 4'd8;
    localparam t_event EV_ALARM_CLEAR = 4'd9;

    localparam t_cred  CRED_MASTER     = 2'd0;
    localparam t_ticks TICKS_MAX       = 16'hFFFF;
    localparam t_ticks TIMEOUT_DEFAULT = 16'd10000;

    typedef struct packed {
        t_op        operation;
        t_zone_code code_zone;
        t_zone_code tag_zone;
        t_mask      breach_mask;
    } t_item;

    // control state apart from the per-zone states
    typedef struct packed {
        t_mode  mode;
        logic   awaiting;
        t_cred  cred;
        t_ticks count;
    } t_ctl;

    typedef struct packed {
        t_mode  system_mode;
        t_mask  armed_mask;
        t_mask  alarm_mask;
        logic   awaiting_tag;
        t_event event_code;
    } t_result;

endpackage

@@ design/zap_in_if.sv @@
// event channel: valid/ready handshake with the event fields
interface zap_in_if;
    import zap_pkg::*;

    logic       valid;
    logic       ready;
    t_op        operation;
    t_zone_code code_zone;
    t_zone_code tag_zone;
    t_mask      breach_mask;

    modport source (output valid, output operation, output code_zone, output tag_zone,
                    output breach_mask, input ready);
    modport sink   (input valid, input operation, input code_zone, input tag_zone,
                    input breach_mask, output ready);
endinterface

@@ design/zap_out_if.sv @@
// result channel: valid/ready handshake with the status fields
interface zap_out_if;
    import zap_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  system_mode;
    t_mask  armed_mask;
    t_mask  alarm_mask;
    logic   awaiting_tag;
    t_event event_code;

    modport source (output valid, output system_mode, output armed_mask, output alarm_mask,
                    output awaiting_tag, output event_code, input ready);
    modport sink   (input valid, input system_mode, input armed_mask, input alarm_mask,
                    input awaiting_tag, input event_code, output ready);
endinterface

@@ design/zap_step.sv @@
// next-state and status logic for one panel event
module zap_step #(
    parameter int ZONE_COUNT = 3
) (
    input  zap_pkg::t_item   i_item,
    input  zap_pkg::t_ctl    i_ctl,
    input  zap_pkg::t_zstate i_zone [ZONE_COUNT],
    input  zap_pkg::t_ticks  i_timeout,
    output zap_pkg::t_ctl    o_ctl,
    output zap_pkg::t_zstate o_zone [ZONE_COUNT],
    output zap_pkg::t_result o_result
);
    import zap_pkg::*;

    localparam int         VIS_ZONES = (ZONE_COUNT < OUT_ZONES) ? ZONE_COUNT : OUT_ZONES;
    localparam logic [3:0] ZC4       = 4'(ZONE_COUNT);

    logic [3:0]            code_u4;
    logic [3:0]            cred_u4;
    logic [ZONE_COUNT-1:0] sel;
    logic                  code_ok;
    logic                  code_trig;
    logic                  sel_armed;
    logic                  trig_other;
    logic                  armed_other;
    logic                  cred_valid;
    logic                  found;
    logic                  go_dis;
    t_ticks                cnt_inc;
    t_event                ev;

    always_comb begin
        code_u4     = {2'b00, i_item.code_zone[1:0]};
        cred_u4     = {2'b00, i_ctl.cred};
        code_trig   = 1'b0;
        sel_armed   = 1'b0;
        trig_other  = 1'b0;
        armed_other = 1'b0;
        for (int i = 0; i < ZONE_COUNT; i++) begin
            sel[i] = (cred_u4 == 4'(i + 1));
            if (code_u4 == 4'(i + 1) && i_zone[i] == ZS_TRIGGERED) code_trig = 1'b1;
            if (sel[i] && i_zone[i] == ZS_ARMED) sel_armed = 1'b1;
            if (!sel[i] && i_zone[i] == ZS_TRIGGERED) trig_other = 1'b1;
            if (!sel[i] && i_zone[i] == ZS_ARMED) armed_other = 1'b1;
        end
        cred_valid = (i_ctl.cred == CRED_MASTER) || (cred_u4 <= ZC4);
        code_ok    = !i_item.code_zone[2] && (code_u4 <= ZC4);
        if (code_ok && i_item.code_zone[1:0] != 2'd0 && i_ctl.mode == MODE_TRIGGERED)
            code_ok = code_trig;
        cnt_inc = (i_ctl.count == TICKS_MAX) ? i_ctl.count : i_ctl.count + 16'd1;

        o_ctl  = i_ctl;
        o_zone = i_zone;
        ev     = EV_NONE;
        go_dis = 1'b0;
        found  = 1'b0;

        case (i_item.operation)
            OP_TICK: begin
                if (i_ctl.awaiting) begin
                    o_ctl.count = cnt_inc;
                    if (cnt_inc >= i_timeout) begin
                        o_ctl.awaiting = 1'b0;
                        o_ctl.count    = '0;
                        ev             = EV_TIMEOUT;
                    end
                end
            end
            OP_CODE: begin
                if (!i_ctl.awaiting) begin
                    if (code_ok) begin
                        o_ctl.cred     = i_item.code_zone[1:0];
                        o_ctl.awaiting = 1'b1;
                        o_ctl.count    = '0;
                        ev             = EV_CODE_OK;
                    end else begin
                        ev = EV_CODE_DENIED;
                    end
                end
            end
            OP_TAG: begin
                if (i_ctl.awaiting) begin
                    o_ctl.awaiting = 1'b0;
                    o_ctl.count    = '0;
                    if (i_item.tag_zone != t_zone_code'({1'b0, i_ctl.cred}) || !cred_valid) begin
                        ev = EV_TAG_REJECT;
                    end else if (i_ctl.mode == MODE_TRIGGERED) begin
                        if (i_ctl.cred == CRED_MASTER || !trig_other) begin
                            go_dis = 1'b1;
                            ev     = EV_SYS_DISARM;
                        end else begin
                            for (int i = 0; i < ZONE_COUNT; i++)
                                if (sel[i]) o_zone[i] = ZS_DISARMED;
                            ev = EV_ALARM_CLEAR;
                        end
                    end else if (i_ctl.mode == MODE_ARMED) begin
                        if (i_ctl.cred == CRED_MASTER || (sel_armed && !armed_other)) begin
                            go_dis = 1'b1;
                            ev     = EV_SYS_DISARM;
                        end else if (sel_armed) begin
                            for (int i = 0; i < ZONE_COUNT; i++)
                                if (sel[i]) o_zone[i] = ZS_DISARMED;
                            ev = EV_ZONE_DISARM;
                        end else begin
                            for (int i = 0; i < ZONE_COUNT; i++)
                                if (sel[i]) o_zone[i] = ZS_ARMED;
                            ev = EV_ARMED;
                        end
                    end else begin
                        for (int i = 0; i < ZONE_COUNT; i++)
                            if (sel[i] || i_ctl.cred == CRED_MASTER) o_zone[i] = ZS_ARMED;
                        o_ctl.mode = MODE_ARMED;
                        ev         = EV_ARMED;
                    end
                end
            end
            OP_BREACH: begin
                if (i_ctl.mode == MODE_ARMED || i_ctl.mode == MODE_TRIGGERED) begin
                    // lowest armed zone with its sensor bit set
                    for (int i = 0; i < VIS_ZONES; i++) begin
                        if (!found && i_zone[i] == ZS_ARMED && i_item.breach_mask[i]) begin
                            o_zone[i] = ZS_TRIGGERED;
                            found     = 1'b1;
                        end
                    end
                    if (found) begin
                        o_ctl.mode     = MODE_TRIGGERED;
                        o_ctl.awaiting = 1'b0;
                        o_ctl.count    = '0;
                        ev             = EV_BREACH;
                    end
                end
            end
            default: ev = EV_NONE;
        endcase

        if (go_dis) begin
            o_ctl.mode = MODE_DISARMED;
            for (int i = 0; i < ZONE_COUNT; i++) o_zone[i] = ZS_DISARMED;
        end

        o_result.system_mode  = o_ctl.mode;
        o_result.armed_mask   = '0;
        o_result.alarm_mask   = '0;
        for (int i = 0; i < VIS_ZONES; i++) begin
            o_result.armed_mask[i] = (o_zone[i] == ZS_ARMED);
            o_result.alarm_mask[i] = (o_zone[i] == ZS_TRIGGERED);
        end
        o_result.awaiting_tag = o_ctl.awaiting;
        o_result.event_code   = ev;
    end

endmodule

@@ design/zoned_alarm_panel_controller_core.sv @@
// top level of the zoned alarm panel controller: registers, handshakes, config
// The panel takes one event per transfer on i_in (tick, code submitted, tag
// scanned or breach report) and returns exactly one status result per event
// on o_out: system mode, armed and alarm masks for zones one to three, the
// awaiting-tag flag and an event code. An event is captured in an input
// register, the whole state update is combinational logic, and the result
// lands in an output register; one event per cycle is sustained while o_out
// keeps taking transfers, and the state update loop sets that rate. The tag
// timeout register is written through i_cfg_wr_en / i_cfg_wr_data and should
// only be changed while no event is in flight.
module zoned_alarm_panel_controller_core #(
    parameter int ZONE_COUNT = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    zap_in_if.sink          i_in,
    zap_out_if.source       o_out,
    input  logic            i_cfg_wr_en,
    input  zap_pkg::t_ticks i_cfg_wr_data
);
    import zap_pkg::*;

    // input stage
    logic    r_s1_valid;
    t_item   r_s1_item;
    // panel state
    t_ctl    r_ctl;
    t_zstate r_zone [ZONE_COUNT];
    t_ticks  r_timeout;
    // result stage
    logic    r_out_valid;
    t_result r_out;

    t_ctl    n_ctl;
    t_zstate n_zone [ZONE_COUNT];
    t_result n_out;
    logic    s1_adv;

    // stage 1 moves on when the result register is empty or being drained
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    zap_step #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_step (
        .i_item    (r_s1_item),
        .i_ctl     (r_ctl),
        .i_zone    (r_zone),
        .i_timeout (r_timeout),
        .o_ctl     (n_ctl),
        .o_zone    (n_zone),
        .o_result  (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item.operation   <= i_in.operation;
            r_s1_item.code_zone   <= i_in.code_zone;
            r_s1_item.tag_zone    <= i_in.tag_zone;
            r_s1_item.breach_mask <= i_in.breach_mask;
        end
    end

    // panel state commits together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode     <= MODE_DISARMED;
            r_ctl.awaiting <= 1'b0;
            r_ctl.cred     <= CRED_MASTER;
            r_ctl.count    <= '0;
            for (int i = 0; i < ZONE_COUNT; i++) r_zone[i] <= ZS_DISARMED;
        end else if (s1_adv) begin
            r_ctl  <= n_ctl;
            r_zone <= n_zone;
        end
    end

    // tag timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.system_mode  = r_out.system_mode;
    assign o_out.armed_mask   = r_out.armed_mask;
    assign o_out.alarm_mask   = r_out.alarm_mask;
    assign o_out.awaiting_tag = r_out.awaiting_tag;
    assign o_out.event_code   = r_out.event_code;

endmodule
